>>> design/rghc_pkg.sv
// Shared types and constants for the RGB gain / hue-preserving clamp block.
package rghc_pkg;

  localparam int CHAN_W      = 8;
  localparam int GAIN_W      = 12;
  localparam int FRAC_BITS   = 4;
  localparam int NUM_CH      = 3;
  localparam int CHAN_MAX    = 255;
  localparam int CLAMP_LIMIT = CHAN_MAX << FRAC_BITS;   // 255.0 in Q.4
  localparam int PROD_W      = CHAN_W + GAIN_W;         // channel * gain
  localparam int DIVIDEND_W  = 2 * CHAN_W;              // channel * 255
  localparam int DIV_STAGES  = CHAN_W;                  // one quotient bit per stage

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(160);

  // queue depth must be a power of two (pointers wrap naturally)
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [CHAN_W-1:0] chan_t;

  // classified pixel, front -> queue -> back
  typedef struct packed {
    logic                    last;
    logic                    clamp;
    chan_t                   maxc;
    chan_t [NUM_CH-1:0]      chan;
  } rghc_item_t;

  // queue status seen by the back end
  typedef struct packed {
    logic full;
    logic empty;
  } rghc_q_status_t;

  // payload of one divider pipeline stage
  typedef struct packed {
    logic                                 last;
    logic                                 clamp;
    chan_t                                maxc;
    logic [NUM_CH-1:0][DIVIDEND_W-1:0]    rem;
    chan_t [NUM_CH-1:0]                   quo;
    chan_t [NUM_CH-1:0]                   nrm;
  } rghc_div_t;

endpackage

>>> design/rghc_front.sv
// Front end: gain register, max-channel search and clamp classification.
module rghc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [rghc_pkg::GAIN_W-1:0]   cfg_gain,
  input  rghc_pkg::chan_t               red,
  input  rghc_pkg::chan_t               green,
  input  rghc_pkg::chan_t               blue,
  input  logic                          last,
  output rghc_pkg::rghc_item_t          item,
  output logic [rghc_pkg::GAIN_W-1:0]   gain
);
  import rghc_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic [GAIN_W-1:0] gain_nxt;
  chan_t             maxc;
  logic [PROD_W-1:0] prod;

  always_comb begin
    gain_nxt = gain_r;
    if (cfg_valid) begin
      gain_nxt = cfg_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else begin
      gain_r <= gain_nxt;
    end
  end

  always_comb begin
    maxc = red;
    if (green > maxc) begin
      maxc = green;
    end
    if (blue > maxc) begin
      maxc = blue;
    end
    prod = PROD_W'(maxc) * PROD_W'(gain_r);
  end

  always_comb begin
    item.chan[CH_RED]   = red;
    item.chan[CH_GREEN] = green;
    item.chan[CH_BLUE]  = blue;
    item.maxc           = maxc;
    item.last           = last;
    item.clamp          = (prod > PROD_W'(CLAMP_LIMIT));
  end

  assign gain = gain_r;

endmodule

>>> design/rghc_queue.sv
// Small FIFO that decouples the classifying front end from the divider back end.
module rghc_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  rghc_pkg::rghc_item_t    push_item,
  input  logic                    pop,
  output rghc_pkg::rghc_item_t    pop_item,
  output rghc_pkg::rghc_q_status_t status
);
  import rghc_pkg::*;

  rghc_item_t          mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_nxt;
  logic [QUEUE_CW-1:0] cnt_r;
  logic [QUEUE_CW-1:0] cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign status.full  = (cnt_r == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = QUEUE_AW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = QUEUE_AW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = QUEUE_CW'(cnt_r + 1'b1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = QUEUE_CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == QUEUE_CW'($past(cnt_r) + 1'b1)))
    else $error("queue count did not grow on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QUEUE_AW'(wr_ptr_r - rd_ptr_r) == QUEUE_AW'(cnt_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> design/rghc_back.sv
// Back end: gain multiply and restoring-division pipeline, result select, output register.
module rghc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rghc_pkg::GAIN_W-1:0]   gain,
  input  rghc_pkg::rghc_q_status_t      q_status,
  input  rghc_pkg::rghc_item_t          q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rghc_pkg::chan_t [rghc_pkg::NUM_CH-1:0] out_chan,
  output logic                          out_last
);
  import rghc_pkg::*;

  rghc_div_t          st_r   [DIV_STAGES+1];
  rghc_div_t          st_nxt [DIV_STAGES+1];
  logic [DIV_STAGES:0] vld_r;
  logic [DIV_STAGES:0] vld_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  chan_t [NUM_CH-1:0] out_chan_r;
  logic               out_last_r;
  logic               en;

  // whole pipeline moves unless a finished result is held by the receiver
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_status.empty;

  always_comb begin
    logic [PROD_W-1:0]     prod;
    logic [DIVIDEND_W-1:0] dsr;
    st_nxt[0].last  = q_item.last;
    st_nxt[0].clamp = q_item.clamp;
    st_nxt[0].maxc  = q_item.maxc;
    st_nxt[0].quo   = '0;
    for (int j = 0; j < NUM_CH; j++) begin
      prod = PROD_W'(q_item.chan[j]) * PROD_W'(gain);
      st_nxt[0].nrm[j] = prod[FRAC_BITS +: CHAN_W];
      // c*255 = c*256 - c
      st_nxt[0].rem[j] = (DIVIDEND_W'(q_item.chan[j]) << CHAN_W) - DIVIDEND_W'(q_item.chan[j]);
    end
    // stage k resolves quotient bit DIV_STAGES-k
    for (int k = 1; k <= DIV_STAGES; k++) begin
      st_nxt[k] = st_r[k-1];
      for (int j = 0; j < NUM_CH; j++) begin
        dsr = DIVIDEND_W'(st_r[k-1].maxc) << (DIV_STAGES - k);
        if (st_r[k-1].rem[j] >= dsr) begin
          st_nxt[k].rem[j]                  = st_r[k-1].rem[j] - dsr;
          st_nxt[k].quo[j][DIV_STAGES - k]  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    if (en) begin
      vld_nxt       = {vld_r[DIV_STAGES-1:0], q_pop};
      out_valid_nxt = vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
      out_chan_r <= st_r[DIV_STAGES].clamp ? st_r[DIV_STAGES].quo : st_r[DIV_STAGES].nrm;
      out_last_r <= st_r[DIV_STAGES].last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_chan  = out_chan_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_clamp_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[DIV_STAGES] && st_r[DIV_STAGES].clamp) |->
      (st_r[DIV_STAGES].quo[CH_RED] == chan_t'(CHAN_MAX) ||
       st_r[DIV_STAGES].quo[CH_GREEN] == chan_t'(CHAN_MAX) ||
       st_r[DIV_STAGES].quo[CH_BLUE] == chan_t'(CHAN_MAX)))
    else $error("clamped pixel lost its 255 peak");

  a_rem_small: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[DIV_STAGES] && st_r[DIV_STAGES].clamp) |->
      (st_r[DIV_STAGES].rem[CH_RED] < DIVIDEND_W'(st_r[DIV_STAGES].maxc) &&
       st_r[DIV_STAGES].rem[CH_GREEN] < DIVIDEND_W'(st_r[DIV_STAGES].maxc) &&
       st_r[DIV_STAGES].rem[CH_BLUE] < DIVIDEND_W'(st_r[DIV_STAGES].maxc)))
    else $error("division remainder not below divisor");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while output held");
`endif

endmodule

>>> design/rgb_gain_hue_preserving_clamp_core.sv
// Top level of the RGB brightness gain with hue-preserving clamp.
//
// Usage:
//  - Input channel (in_valid / in_stall): one RGB pixel per transaction, taken at
//    a rising edge with in_valid high and in_stall low. in_stall rises only when
//    the internal four-entry queue is full.
//  - Output channel (out_valid / out_stall): one result per input, in order.
//    A stalled result holds its data until out_stall drops.
//  - Config channel (cfg_valid / cfg_ready): writes the 12-bit Q8.4 gain;
//    cfg_ready is always high. Write only while no pixel is in flight.
//  - Path from input acceptance to out_valid: queue, multiply stage, eight
//    restoring-division stages, output register.
//  - Throughput: one pixel per cycle while out_stall does not hold a result; the
//    division is pipelined one quotient bit per stage, so the eight-stage divider sets the latency, not the rate.
//  - When out_stall is high with a result pending, the whole back pipeline
//    freezes; the queue keeps absorbing up to four pixels before in_stall.
//  - Synchronous active-low reset empties the queue and pipeline and loads
//    the gain with 10.0 (160).
module rgb_gain_hue_preserving_clamp_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_gain,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_last_out
);
  import rghc_pkg::*;

  rghc_item_t         fr_item;
  rghc_item_t         q_item;
  rghc_q_status_t     q_status;
  logic [GAIN_W-1:0]  gain;
  logic               q_pop;
  chan_t [NUM_CH-1:0] out_chan;

  assign cfg_ready = 1'b1;
  // queue full is the only reason to hold off the source
  assign in_stall  = q_status.full;

  rghc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_gain  (cfg_gain),
    .red       (in_red_in),
    .green     (in_green_in),
    .blue      (in_blue_in),
    .last      (in_last_in),
    .item      (fr_item),
    .gain      (gain)
  );

  rghc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !in_stall),
    .push_item (fr_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .status    (q_status)
  );

  rghc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (gain),
    .q_status  (q_status),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_chan  (out_chan),
    .out_last  (out_last_out)
  );

  assign out_red_out   = out_chan[CH_RED];
  assign out_green_out = out_chan[CH_GREEN];
  assign out_blue_out  = out_chan[CH_BLUE];

endmodule

>>> tb/tb_rgb_gain_hue_preserving_clamp_core.sv
// Self-checking testbench for the RGB brightness gain with hue-preserving clamp.
module tb_rgb_gain_hue_preserving_clamp_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rghc_pkg::*;

  // Run shape
  localparam int RAND_PER_PHASE = 120;     // random pixels after each gain setting
  localparam int TAIL_ITEMS     = 100;     // last stretch of the run has no idling
  localparam int LONG_HOLD      = 64;      // output hold-off, long enough to back up the input
  localparam int HOLD_AT_A      = 300;     // pixel counts that trigger the long holds
  localparam int HOLD_AT_B      = 1000;
  localparam int DRAIN_CYCLES   = 30;      // drain time after all results are back, before the final check
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } pixel_t;

  typedef enum bit {PIXEL_TXN, GAIN_TXN} stim_kind_t;

  typedef struct {
    stim_kind_t        kind;
    pixel_t            pix;
    logic [GAIN_W-1:0] gain;
  } stim_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [GAIN_W-1:0] cfg_gain  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  chan_t             in_red_in   = '0;
  chan_t             in_green_in = '0;
  chan_t             in_blue_in  = '0;
  logic              in_last_in  = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  chan_t             out_red_out;
  chan_t             out_green_out;
  chan_t             out_blue_out;
  logic              out_last_out;

  rgb_gain_hue_preserving_clamp_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_gain      (cfg_gain),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_last_in    (in_last_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_last_out  (out_last_out)
  );

  // Pending transactions (pixels and gain writes, in order) and the scaled
  // pixels the block still owes us.
  stim_t  stimulus[$];
  pixel_t expected_pixels[$];

  logic [GAIN_W-1:0] gain_model   = GAIN_RESET;  // our copy of the gain register
  int                gap_left     = 0;           // sender idle cycles still to insert
  int                stall_left   = 0;           // receiver stall cycles still to insert
  bit [1:0]          hold_done    = '0;
  bit                calm         = 1'b0;        // set near the end: no idling
  int unsigned       pix_accepted = 0;
  int unsigned       n_results    = 0;
  int unsigned       n_clamped    = 0;
  int unsigned       n_gains      = 0;
  int unsigned       n_errors     = 0;
  int unsigned       cycles       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pixel scaler prediction.
  // Brightest channel m decides the case: if m*gain exceeds 255.0 (in Q.4) the
  // whole pixel is scaled so m lands on exactly 255 (floor(c*255/m)); otherwise
  // every channel is floor(c*gain/16). m >= 1 whenever the clamp fires.
  // ---------------------------------------------------------------------------
  function automatic pixel_t scale_pixel(input pixel_t p, input logic [GAIN_W-1:0] g,
                                         output bit clamped);
    int unsigned chan[3];
    int unsigned scaled[3];
    int unsigned peak;
    pixel_t      q;
    chan[0] = p.red;
    chan[1] = p.green;
    chan[2] = p.blue;
    peak = chan[0];
    for (int i = 1; i < 3; i++) if (chan[i] > peak) peak = chan[i];
    clamped = (peak * g) > CLAMP_LIMIT;
    for (int i = 0; i < 3; i++)
      scaled[i] = clamped ? (chan[i] * CHAN_MAX) / peak : (chan[i] * g) >> FRAC_BITS;
    q.red   = chan_t'(scaled[0]);
    q.green = chan_t'(scaled[1]);
    q.blue  = chan_t'(scaled[2]);
    q.last  = p.last;
    return q;
  endfunction

  function automatic void add_pixel(int r, int g, int b, bit last);
    stim_t s;
    s.kind = PIXEL_TXN;
    s.pix  = '{red: chan_t'(r), green: chan_t'(g), blue: chan_t'(b), last: last};
    s.gain = '0;
    stimulus.push_back(s);
  endfunction

  function automatic void add_gain(int unsigned g);
    stim_t s;
    s.kind = GAIN_TXN;
    s.pix  = '0;
    s.gain = GAIN_W'(g);
    stimulus.push_back(s);
  endfunction

  // Random pixel, biased toward the interesting region for gain g: pixels
  // whose brightest channel sits right at the clamp threshold, pixels at or
  // under it (normal path at high gain), greys, and plain uniform ones.
  function automatic void add_random_pixel(int unsigned g);
    int unsigned thr;
    int unsigned peak;
    int unsigned ch[3];
    int          pos;
    bit          last;
    last = ($urandom_range(0, 7) == 0);
    thr  = (g == 0) ? CHAN_MAX : CLAMP_LIMIT / g;
    if (thr > CHAN_MAX) thr = CHAN_MAX;
    case ($urandom_range(0, 9))
      0, 1: begin
        peak = thr + $urandom_range(0, 1);
        if (peak > CHAN_MAX) peak = CHAN_MAX;
      end
      2, 3: peak = $urandom_range(0, thr);
      4: begin
        peak = $urandom_range(0, CHAN_MAX);
        add_pixel(peak, peak, peak, last);
        return;
      end
      default: begin
        add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), last);
        return;
      end
    endcase
    // brightest channel at a random position, the others at or below it
    pos = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) ch[i] = (i == pos) ? peak : $urandom_range(0, peak);
    add_pixel(ch[0], ch[1], ch[2], last);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending pixels on the input channel and gain writes on the
  // config port. A gain write only goes out once every accepted pixel has come
  // back, so the register never changes under a pixel in flight.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stim_t  nxt;
    pixel_t want;
    bit     took;
    bit     clamped;
    bit     vld_nxt;
    bit     cfg_nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      cfg_valid  <= 1'b0;
      gain_model <= GAIN_RESET;
      gap_left   <= 0;
    end else begin
      took    = in_valid && !in_stall;
      vld_nxt = in_valid;
      cfg_nxt = cfg_valid;

      if (cfg_valid && cfg_ready) begin
        gain_model <= cfg_gain;
        n_gains    <= n_gains + 1;
        cfg_nxt    = 1'b0;
      end

      // accepted transaction: predict its result with the gain in force now
      if (took) begin
        want = scale_pixel('{in_red_in, in_green_in, in_blue_in, in_last_in},
                           gain_model, clamped);
        expected_pixels.push_back(want);
        pix_accepted <= pix_accepted + 1;
        n_clamped    <= n_clamped + clamped;
        vld_nxt      = 1'b0;
      end

      if (vld_nxt) begin
        // stalled: payload holds
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (stimulus.size() != 0 && !cfg_nxt) begin
        if (stimulus[0].kind == PIXEL_TXN) begin
          nxt = stimulus.pop_front();
          in_red_in   <= nxt.pix.red;
          in_green_in <= nxt.pix.green;
          in_blue_in  <= nxt.pix.blue;
          in_last_in  <= nxt.pix.last;
          vld_nxt     = 1'b1;
          // idle burst after this pixel goes through
          if (!calm && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 6);
        end else if (!took && pix_accepted == n_results) begin
          nxt = stimulus.pop_front();
          cfg_gain <= nxt.gain;
          cfg_nxt  = 1'b1;
        end
      end

      in_valid  <= vld_nxt;
      cfg_valid <= cfg_nxt;
      calm      <= (stimulus.size() < TAIL_ITEMS);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: short random stall bursts, plus two long holds
  // while the sender keeps going, so the internal queue fills and in_stall
  // has to rise.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int left;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      left = stall_left;
      if (!hold_done[0] && pix_accepted >= HOLD_AT_A) begin
        left = LONG_HOLD;
        hold_done[0] <= 1'b1;
      end else if (!hold_done[1] && pix_accepted >= HOLD_AT_B) begin
        left = LONG_HOLD;
        hold_done[1] <= 1'b1;
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        left = $urandom_range(0, 5);   // start a new stall burst
      end else begin
        out_stall <= 1'b0;
      end
      stall_left <= left;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transaction is checked against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_red_out, out_green_out, out_blue_out, out_last_out};
      n_results <= n_results + 1;
      if (expected_pixels.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("[%0t] unexpected result r=%0d g=%0d b=%0d last=%0b",
                   $realtime, got.red, got.green, got.blue, got.last);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.last !== want.last) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("[%0t] mismatch: exp rgb/last %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                     $realtime, want.red, want.green, want.blue, want.last,
                     got.red, got.green, got.blue, got.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gain_plan[$];
    int unsigned g;

    // Directed pixels at the reset gain of 10.0: clamp fires once the
    // brightest channel reaches 26 (26*160 > 4080), not at 25.
    add_pixel(0, 0, 0, 0);          // black pixel
    add_pixel(255, 255, 255, 1);    // full white
    add_pixel(25, 0, 0, 0);         // largest channel still on the normal path
    add_pixel(26, 13, 0, 0);        // first value that clamps
    add_pixel(0, 25, 10, 1);
    add_pixel(0, 0, 26, 0);
    add_pixel(128, 64, 255, 1);     // peak in blue
    add_pixel(255, 0, 128, 0);      // peak in red
    add_pixel(1, 2, 3, 1);
    add_pixel(10, 10, 10, 0);
    add_pixel(170, 85, 85, 1);
    for (int i = 0; i < RAND_PER_PHASE; i++) add_random_pixel(GAIN_RESET);

    // Gain 15.0: 17*240 is exactly 255.0, which must stay unclamped.
    add_gain(240);
    add_pixel(17, 5, 0, 0);
    add_pixel(0, 17, 16, 1);
    add_pixel(18, 1, 0, 0);
    for (int i = 0; i < RAND_PER_PHASE; i++) add_random_pixel(240);

    add_gain(0);                    // zero gain: everything black
    add_pixel(255, 255, 255, 1);
    for (int i = 0; i < RAND_PER_PHASE; i++) add_random_pixel(0);

    add_gain(4095);                 // max gain: any nonzero pixel clamps
    add_pixel(1, 1, 1, 0);
    add_pixel(1, 0, 0, 1);
    for (int i = 0; i < RAND_PER_PHASE; i++) add_random_pixel(4095);

    add_gain(16);                   // unity gain, never clamps
    add_pixel(255, 128, 1, 0);
    for (int i = 0; i < RAND_PER_PHASE; i++) add_random_pixel(16);

    // remaining settings: smallest nonzero, a few odd ones, random ones, then the reset value
    gain_plan = '{1, 17, 255, 2048};
    repeat (4) gain_plan.push_back($urandom_range(0, 4095));
    gain_plan.push_back(GAIN_RESET);  // write the reset value back explicitly
    foreach (gain_plan[k]) begin
      g = gain_plan[k];
      add_gain(g);
      for (int i = 0; i < RAND_PER_PHASE; i++) add_random_pixel(g);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // all transactions out, all results back
    while (stimulus.size() != 0 || in_valid || cfg_valid || pix_accepted != n_results)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_pixels.size() != 0) begin
      $display("%0d results never arrived", expected_pixels.size());
      n_errors += expected_pixels.size();
    end

    $display("Ran %0d pixels through %0d gain writes; %0d took the hue-preserving clamp.",
             n_results, n_gains, n_clamped);
    $display("Mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
